>>> sv/gspf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gspf_pkg;

  // Field and datapath widths
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 48;
  localparam int POLE_W  = 16;
  localparam int ERR_W   = SPEED_W + 1;
  localparam int ERR2_W  = ERR_W + 1;
  localparam int ACC_W   = 64;
  localparam int PROD_W  = GAIN_W + ERR2_W;
  localparam int SUM_W   = ACC_W + 2;
  localparam int FUEL_W  = 16;
  localparam int Q_FRAC  = 40;
  localparam int CFG_IDX_W = 3;

  // Register indexes on the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCHED_SPEED = 3'd0,
    CFG_KP_LOW      = 3'd1,
    CFG_KP_HIGH     = 3'd2,
    CFG_KI_LOW      = 3'd3,
    CFG_KI_HIGH     = 3'd4,
    CFG_KD_LOW      = 3'd5,
    CFG_KD_HIGH     = 3'd6,
    CFG_DERIV_POLE  = 3'd7
  } cfg_idx_t;

  // Reset values of the tuning registers
  localparam logic [SPEED_W-1:0]       SCHED_SPEED_RST = 16'd0;
  localparam logic signed [GAIN_W-1:0] KP_LOW_RST      = 48'sd329841091;
  localparam logic signed [GAIN_W-1:0] KP_HIGH_RST     = 48'sd348413821;
  localparam logic signed [GAIN_W-1:0] KI_LOW_RST      = 48'sd0;
  localparam logic signed [GAIN_W-1:0] KI_HIGH_RST     = 48'sd0;
  localparam logic signed [GAIN_W-1:0] KD_LOW_RST      = 48'sd39246628;
  localparam logic signed [GAIN_W-1:0] KD_HIGH_RST     = 48'sd36572313;
  localparam logic [POLE_W-1:0]        DERIV_POLE_RST  = 16'd59297;

  // Saturate a wide signed value to the accumulator range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [PROD_W-1:0] v);
    logic ovf;
    ovf = (v[PROD_W-1:ACC_W-1] != {(PROD_W-ACC_W+1){1'b0}}) &&
          (v[PROD_W-1:ACC_W-1] != {(PROD_W-ACC_W+1){1'b1}});
    if (!ovf) begin
      sat_acc = v[ACC_W-1:0];
    end else if (v[PROD_W-1]) begin
      sat_acc = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sat_acc = {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/gspf_sat_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module gspf_sat_mul (
  input  wire logic signed [gspf_pkg::GAIN_W-1:0] gain,
  input  wire logic signed [gspf_pkg::ERR2_W-1:0] err,
  output logic signed [gspf_pkg::ACC_W-1:0]       prod
);
  import gspf_pkg::*;

  logic signed [PROD_W-1:0] prod_full;

  // Exact product, then clip to the accumulator range
  assign prod_full = PROD_W'(gain) * PROD_W'(err);
  assign prod      = sat_acc(prod_full);

endmodule

`default_nettype wire

>>> sv/gain_scheduled_pid_fuel_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Width  Contents
// s_tdata   in   32     target_speed [15:0], measured_speed [31:16]
// m_tdata   out  16     fuel_frac [15:0]
// m_tuser   out  2      clamped_low [0], clamped_high [1]
// cfg_*     in   3/48   register index, write data (sign extended gains, low bits else)
//
// One sample per cycle unless stalled; stages: input, products, sums, result. The cycle time
// is set by the accumulator stage: derivative pole multiply (64 x 16) plus a saturating add.
// rst clears all stage valids, the integral and derivative sums, the prior error,
// and loads the default tuning values.
// While m_tready is low and a result waits, the whole pipeline holds and s_tready drops.
module gain_scheduled_pid_fuel_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [31:0]                   s_tdata,  // target_speed, measured_speed
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [15:0]                        m_tdata,  // fuel_frac
  output logic [1:0]                         m_tuser,  // clamped_low, clamped_high
  input  wire logic                          cfg_wr_en,
  input  wire logic [gspf_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [gspf_pkg::GAIN_W-1:0]   cfg_wdata
);
  import gspf_pkg::*;

  // Tuning registers
  logic [SPEED_W-1:0]       sched_speed;
  logic signed [GAIN_W-1:0] kp_low, kp_high, ki_low, ki_high, kd_low, kd_high;
  logic [POLE_W-1:0]        deriv_pole;

  // Pipeline control
  logic adv;
  logic v1, v2, v3;

  // Stage 1: input register
  logic [SPEED_W-1:0] target_r, meas_r;

  // Stage 2: error, gain selection, products
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  prior_error;
  logic signed [ERR2_W-1:0] err_x, err_sum, err_diff;
  logic                     low_set;
  logic signed [GAIN_W-1:0] kp_sel, ki_sel, kd_sel;
  logic signed [ACC_W-1:0]  p_mul, i_mul, d_mul;
  logic signed [ACC_W-1:0]  p2, pi2, pd2;

  // Stage 3: accumulators
  logic signed [ACC_W-1:0]  integral_sum, deriv_sum;
  logic signed [ACC_W-1:0]  integral_next, deriv_next;
  logic [ACC_W-1:0]         deriv_mag;
  logic [ACC_W+POLE_W-1:0]  deriv_scaled;
  logic signed [ACC_W-1:0]  deriv_fb;
  logic signed [ACC_W-1:0]  p3;

  // Stage 4: total and clamp
  logic signed [SUM_W-1:0]  total;
  logic [FUEL_W-1:0]        fuel_next;
  logic                     cl_next, ch_next;
  logic [FUEL_W-1:0]        fuel_frac;
  logic                     clamped_low, clamped_high;

  // Advance whenever the output register is free or being drained
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sched_speed <= SCHED_SPEED_RST;
      kp_low      <= KP_LOW_RST;
      kp_high     <= KP_HIGH_RST;
      ki_low      <= KI_LOW_RST;
      ki_high     <= KI_HIGH_RST;
      kd_low      <= KD_LOW_RST;
      kd_high     <= KD_HIGH_RST;
      deriv_pole  <= DERIV_POLE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_SCHED_SPEED: sched_speed <= cfg_wdata[SPEED_W-1:0];
        CFG_KP_LOW:      kp_low      <= cfg_wdata;
        CFG_KP_HIGH:     kp_high     <= cfg_wdata;
        CFG_KI_LOW:      ki_low      <= cfg_wdata;
        CFG_KI_HIGH:     ki_high     <= cfg_wdata;
        CFG_KD_LOW:      kd_low      <= cfg_wdata;
        CFG_KD_HIGH:     kd_high     <= cfg_wdata;
        CFG_DERIV_POLE:  deriv_pole  <= cfg_wdata[POLE_W-1:0];
      endcase
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      m_tvalid <= v3;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (adv && s_tvalid) begin
      target_r <= s_tdata[SPEED_W-1:0];
      meas_r   <= s_tdata[2*SPEED_W-1:SPEED_W];
    end
  end

  // Error terms and gain set
  assign err      = $signed({1'b0, target_r}) - $signed({1'b0, meas_r});
  assign err_x    = ERR2_W'(err);
  assign err_sum  = ERR2_W'(err) + ERR2_W'(prior_error);
  assign err_diff = ERR2_W'(err) - ERR2_W'(prior_error);
  assign low_set  = meas_r <= sched_speed;
  assign kp_sel   = low_set ? kp_low : kp_high;
  assign ki_sel   = low_set ? ki_low : ki_high;
  assign kd_sel   = low_set ? kd_low : kd_high;

  gspf_sat_mul u_mul_p (.gain(kp_sel), .err(err_x),    .prod(p_mul));
  gspf_sat_mul u_mul_i (.gain(ki_sel), .err(err_sum),  .prod(i_mul));
  gspf_sat_mul u_mul_d (.gain(kd_sel), .err(err_diff), .prod(d_mul));

  // Register products and remember this error
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_error <= '0;
    end else if (adv && v1) begin
      prior_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1) begin
      p2  <= p_mul;
      pi2 <= i_mul;
      pd2 <= d_mul;
    end
  end

  // Derivative feedback: pole times previous sum, truncated toward zero
  assign deriv_mag    = deriv_sum[ACC_W-1] ? (~deriv_sum[ACC_W-1:0] + ACC_W'(1)) : deriv_sum;
  assign deriv_scaled = (ACC_W+POLE_W)'(deriv_mag) * (ACC_W+POLE_W)'(deriv_pole);
  assign deriv_fb     = deriv_sum[ACC_W-1] ?
                        -$signed({1'b0, deriv_scaled[ACC_W+POLE_W-2:POLE_W]}) :
                         $signed({1'b0, deriv_scaled[ACC_W+POLE_W-2:POLE_W]});

  assign integral_next = sat_acc(PROD_W'(integral_sum) + PROD_W'(pi2));
  assign deriv_next    = sat_acc(PROD_W'(deriv_fb) + PROD_W'(pd2));

  // Update accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      deriv_sum    <= '0;
    end else if (adv && v2) begin
      integral_sum <= integral_next;
      deriv_sum    <= deriv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2) begin
      p3 <= p2;
    end
  end

  // Exact total and clamp to the fuel range
  assign total = SUM_W'(p3) + SUM_W'(integral_sum) + SUM_W'(deriv_sum);

  always_comb begin
    cl_next   = 1'b0;
    ch_next   = 1'b0;
    fuel_next = '0;
    if (total[SUM_W-1]) begin
      cl_next = 1'b1;
    end else if (total > SUM_W'(1) << Q_FRAC) begin
      ch_next   = 1'b1;
      fuel_next = '1;
    end else if (total[Q_FRAC]) begin
      fuel_next = '1;
    end else begin
      fuel_next = total[Q_FRAC-1:Q_FRAC-FUEL_W];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv && v3) begin
      fuel_frac    <= fuel_next;
      clamped_low  <= cl_next;
      clamped_high <= ch_next;
    end
  end

  assign m_tdata = fuel_frac;
  assign m_tuser = {clamped_high, clamped_low};

endmodule

`default_nettype wire

>>> sim/fuel_pid_checker.sv
`timescale 1ns / 1ps

module fuel_pid_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [31:0]                        s_tdata,  // target_speed, measured_speed
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [15:0]                        m_tdata,  // fuel_frac
  input  logic [1:0]                         m_tuser,  // clamped_low, clamped_high
  input  logic                               cfg_wr_en,
  input  logic [gspf_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [gspf_pkg::GAIN_W-1:0]        cfg_wdata,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 n_in_range,
  output int                                 n_clamp_low,
  output int                                 n_clamp_high
);
  import gspf_pkg::*;

  localparam logic signed [79:0] ACC_MAX  = {17'd0, {63{1'b1}}};
  localparam logic signed [79:0] ACC_MIN  = {{17{1'b1}}, 63'd0};
  localparam logic signed [79:0] FULL_ONE = {39'd0, 1'b1, 40'd0};

  typedef struct packed {
    logic [FUEL_W-1:0] fuel;
    logic              low_clamp;
    logic              high_clamp;
  } fuel_result_t;

  fuel_result_t fuel_q[$];

  // Tuning copy, written alongside the block
  logic [SPEED_W-1:0]       sched_speed;
  logic signed [GAIN_W-1:0] kp_lo, kp_hi, ki_lo, ki_hi, kd_lo, kd_hi;
  logic [POLE_W-1:0]        pole;

  // Controller state
  logic signed [63:0]       integ_acc;
  logic signed [63:0]       deriv_acc;
  logic signed [ERR_W-1:0]  prior_err;

  // Clamp an exact value to the signed 64 bit range
  function automatic logic signed [63:0] sat64(input logic signed [79:0] v);
    if (v > ACC_MAX) return ACC_MAX[63:0];
    if (v < ACC_MIN) return ACC_MIN[63:0];
    return v[63:0];
  endfunction

  // One controller sample: update the sums and form the clamped fuel fraction
  task automatic predict_fuel(input logic [SPEED_W-1:0] tgt, input logic [SPEED_W-1:0] meas,
                              output fuel_result_t res);
    logic signed [ERR_W-1:0]  err;
    logic signed [ERR2_W-1:0] err_sum, err_diff;
    logic signed [GAIN_W-1:0] kp, ki, kd;
    logic signed [79:0]       wide;
    logic signed [63:0]       p_term, i_step, d_step, d_fb;
    logic [63:0]              d_mag;
    logic [79:0]              fb_prod;
    err = $signed({1'b0, tgt}) - $signed({1'b0, meas});
    err_sum = ERR2_W'(err) + ERR2_W'(prior_err);
    err_diff = ERR2_W'(err) - ERR2_W'(prior_err);
    if (meas <= sched_speed) begin
      kp = kp_lo; ki = ki_lo; kd = kd_lo;
    end else begin
      kp = kp_hi; ki = ki_hi; kd = kd_hi;
    end
    wide = 80'(kp) * 80'(err);
    p_term = sat64(wide);
    wide = 80'(ki) * 80'(err_sum);
    i_step = sat64(wide);
    wide = 80'(integ_acc) + 80'(i_step);
    integ_acc = sat64(wide);
    // filter feedback truncates toward zero
    d_mag = deriv_acc[63] ? -deriv_acc : deriv_acc;
    fb_prod = 80'(d_mag) * 80'(pole);
    d_fb = deriv_acc[63] ? -$signed(fb_prod[79:16]) : $signed(fb_prod[79:16]);
    wide = 80'(kd) * 80'(err_diff);
    d_step = sat64(wide);
    wide = 80'(d_fb) + 80'(d_step);
    deriv_acc = sat64(wide);
    prior_err = err;
    wide = 80'(p_term) + 80'(integ_acc) + 80'(deriv_acc);
    res = '0;
    if (wide < 0) begin
      res.low_clamp = 1'b1;
    end else if (wide > FULL_ONE) begin
      res.fuel = '1;
      res.high_clamp = 1'b1;
    end else begin
      res.fuel = wide[40] ? {FUEL_W{1'b1}} : wide[39:24];
    end
  endtask

  always @(posedge clk) begin : monitor
    fuel_result_t want;
    logic bad;
    if (rst) begin
      sched_speed = SCHED_SPEED_RST;
      kp_lo = KP_LOW_RST;  kp_hi = KP_HIGH_RST;
      ki_lo = KI_LOW_RST;  ki_hi = KI_HIGH_RST;
      kd_lo = KD_LOW_RST;  kd_hi = KD_HIGH_RST;
      pole = DERIV_POLE_RST;
      integ_acc = '0;
      deriv_acc = '0;
      prior_err = '0;
      fuel_q.delete();
    end else begin
      // Retire a result beat against the oldest prediction
      if (m_tvalid && m_tready) begin
        if (fuel_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: fuel_frac %0d flags %b",
                   $time, m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = fuel_q.pop_front();
          bad = 1'b0;
          if (m_tdata !== want.fuel) begin
            $display("%0t: fuel_frac expected %0d got %0d", $time, want.fuel, m_tdata);
            bad = 1'b1;
          end
          if (m_tuser[0] !== want.low_clamp) begin
            $display("%0t: clamped_low expected %b got %b", $time, want.low_clamp, m_tuser[0]);
            bad = 1'b1;
          end
          if (m_tuser[1] !== want.high_clamp) begin
            $display("%0t: clamped_high expected %b got %b", $time, want.high_clamp,
                     m_tuser[1]);
            bad = 1'b1;
          end
          if (bad) fail_count++;
          if (want.low_clamp) n_clamp_low++;
          else if (want.high_clamp) n_clamp_high++;
          else n_in_range++;
        end
      end
      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_SCHED_SPEED: sched_speed = cfg_wdata[SPEED_W-1:0];
          CFG_KP_LOW:      kp_lo = cfg_wdata;
          CFG_KP_HIGH:     kp_hi = cfg_wdata;
          CFG_KI_LOW:      ki_lo = cfg_wdata;
          CFG_KI_HIGH:     ki_hi = cfg_wdata;
          CFG_KD_LOW:      kd_lo = cfg_wdata;
          CFG_KD_HIGH:     kd_hi = cfg_wdata;
          CFG_DERIV_POLE:  pole = cfg_wdata[POLE_W-1:0];
          default: ;
        endcase
      end
      // Predict the result of an accepted sample beat
      if (s_tvalid && s_tready) begin
        predict_fuel(s_tdata[15:0], s_tdata[31:16], want);
        fuel_q.push_back(want);
      end
    end
    pending = fuel_q.size();
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gspf_pkg::*;

  localparam int CYCLE_LIMIT       = 300000;
  localparam int TUNING_PHASES     = 8;
  localparam int SAMPLES_PER_PHASE = 75;
  localparam int HOLD_CYCLES       = 300;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid, s_tready;
  logic [31:0]          s_tdata;
  logic                 m_tvalid, m_tready;
  logic [15:0]          m_tdata;
  logic [1:0]           m_tuser;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [GAIN_W-1:0]    cfg_wdata;

  int fail_count, pending, n_in_range, n_clamp_low, n_clamp_high;
  int hold_reqs = 0;
  int cycle_count = 0;
  int samples_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gain_scheduled_pid_fuel_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  fuel_pid_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .n_in_range   (n_in_range),
    .n_clamp_low  (n_clamp_low),
    .n_clamp_high (n_clamp_high)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: stall modes that change every so often, plus long hold-offs on request
  initial begin : receiver
    int hold_left;
    int served;
    int mode;
    int mode_left;
    m_tready = 1'b0;
    hold_left = 0;
    served = 0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && served != hold_reqs) begin
        served = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        case (mode)
          0: m_tready = 1'b1;
          1: m_tready = 1'($urandom_range(0, 1));
          2: m_tready = ($urandom_range(0, 3) == 0);
          default: m_tready = (mode_left % 3 != 0);
        endcase
      end
    end
  end

  // Offer one sample beat and hold it until accepted
  task automatic send_sample(input logic [15:0] tgt, input logic [15:0] meas);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {meas, tgt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata = $urandom;
    end
  endtask

  // Stop offering and wait for every predicted result to come out
  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_tuning(input logic [15:0] sched, input logic [GAIN_W-1:0] kp_l,
                             input logic [GAIN_W-1:0] kp_h, input logic [GAIN_W-1:0] ki_l,
                             input logic [GAIN_W-1:0] ki_h, input logic [GAIN_W-1:0] kd_l,
                             input logic [GAIN_W-1:0] kd_h, input logic [15:0] pole);
    logic [GAIN_W-1:0] vals [8];
    vals[CFG_SCHED_SPEED] = GAIN_W'(sched);
    vals[CFG_KP_LOW]      = kp_l;
    vals[CFG_KP_HIGH]     = kp_h;
    vals[CFG_KI_LOW]      = ki_l;
    vals[CFG_KI_HIGH]     = ki_h;
    vals[CFG_KD_LOW]      = kd_l;
    vals[CFG_KD_HIGH]     = kd_h;
    vals[CFG_DERIV_POLE]  = GAIN_W'(pole);
    for (int i = 0; i <= int'(CFG_DERIV_POLE); i++) begin
      @(negedge clk);
      cfg_wr_en = 1'b1;
      cfg_addr = cfg_idx_t'(i);
      cfg_wdata = vals[cfg_addr];
    end
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Gain with a bounded magnitude and occasional negative sign; full width when unbounded
  function automatic logic [GAIN_W-1:0] rand_gain(input int mag_bits);
    logic [GAIN_W-1:0] g;
    g = GAIN_W'({$urandom, $urandom});
    if (mag_bits < GAIN_W) begin
      g = g & ((48'd1 << mag_bits) - 48'd1);
      if ($urandom_range(0, 3) == 0) g = -g;
    end
    return g;
  endfunction

  // Mostly tracking errors within a span, some near the scheduling speed, some noise
  task automatic pick_sample(input int span, input int sched, output logic [15:0] tgt,
                             output logic [15:0] meas);
    int m, t, r;
    r = $urandom_range(0, span);
    case ($urandom_range(0, 9))
      0, 1: begin
        m = $urandom_range(0, 65535);
        t = $urandom_range(0, 65535);
      end
      2: begin
        m = sched + int'($urandom_range(0, 6)) - 3;
        t = m + r - span / 2;
      end
      default: begin
        m = $urandom_range(0, 65535);
        t = m + r - span / 2;
      end
    endcase
    if (m < 0) m = 0;
    if (m > 65535) m = 65535;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    tgt = 16'(t);
    meas = 16'(m);
  endtask

  task automatic send_run(input int count, input int span, input int sched);
    logic [15:0] tgt, meas;
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > count) burst = count;
      repeat (burst) begin
        pick_sample(span, sched, tgt, meas);
        send_sample(tgt, meas);
      end
      count -= burst;
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
  endtask

  initial begin : stimulus
    logic [15:0] sched, pole, tgt, meas;
    int span;
    int left;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_addr = CFG_SCHED_SPEED;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset tuning: zero error, both extremes of error, both gain sets
    send_sample(16'd0, 16'd0);
    send_sample(16'd65535, 16'd65535);
    send_sample(16'd65535, 16'd0);
    send_sample(16'd0, 16'd65535);
    send_sample(16'd1000, 16'd0);
    send_sample(16'd1500, 16'd1);
    send_sample(16'd3000, 16'd2900);
    send_sample(16'd2900, 16'd3000);
    drain_results();

    // Proportional only, error of 1024 lands exactly on full fuel
    load_tuning(16'hFFFF, 48'h0000_4000_0000, KP_HIGH_RST, 48'd0, 48'd0, 48'd0, 48'd0,
                16'd0);
    send_sample(16'd1024, 16'd0);
    send_sample(16'd1023, 16'd0);
    send_sample(16'd1025, 16'd0);
    send_sample(16'd0, 16'd1);
    send_sample(16'd5000, 16'd3976);
    send_sample(16'd0, 16'd0);
    drain_results();

    // Extreme gains and pole: products and both accumulators saturate
    load_tuning(16'd32768, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
                48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 16'hFFFF);
    send_sample(16'd65535, 16'd0);
    send_sample(16'd65535, 16'd0);
    send_sample(16'd0, 16'd65535);
    send_sample(16'd0, 16'd65535);
    send_sample(16'd0, 16'd32768);
    send_sample(16'd0, 16'd32769);
    send_sample(16'd32768, 16'd32768);
    drain_results();

    // Random tuning phases; the last one goes back to the reset values
    for (int ph = 0; ph < TUNING_PHASES; ph++) begin
      drain_results();
      if (ph == TUNING_PHASES - 1) begin
        sched = SCHED_SPEED_RST;
        span = 4000;
        load_tuning(SCHED_SPEED_RST, KP_LOW_RST, KP_HIGH_RST, KI_LOW_RST, KI_HIGH_RST,
                    KD_LOW_RST, KD_HIGH_RST, DERIV_POLE_RST);
      end else begin
        sched = 16'($urandom_range(0, 65535));
        pole = 16'($urandom_range(0, 65535));
        if (ph % 3 == 1) begin
          span = 65535;
          load_tuning(sched, rand_gain(GAIN_W), rand_gain(GAIN_W), rand_gain(GAIN_W),
                      rand_gain(GAIN_W), rand_gain(GAIN_W), rand_gain(GAIN_W), pole);
        end else begin
          case ($urandom_range(0, 2))
            0: span = 200;
            1: span = 3000;
            default: span = 65535;
          endcase
          load_tuning(sched, rand_gain(30), rand_gain(30), rand_gain(20), rand_gain(20),
                      rand_gain(28), rand_gain(28), pole);
        end
      end
      left = SAMPLES_PER_PHASE;
      // Hold off the result side while samples keep coming, so the pipe backs up
      if (ph == 1 || ph == 5) begin
        @(negedge clk);
        hold_reqs++;
        repeat (40) begin
          pick_sample(span, int'(sched), tgt, meas);
          send_sample(tgt, meas);
        end
        left -= 40;
      end
      send_run(left, span, int'(sched));
    end

    drain_results();
    repeat (20) @(negedge clk);
    $display("%0d samples over %0d tuning settings, %0d long output stalls",
             samples_sent, TUNING_PHASES + 3, hold_reqs);
    $display("fuel results: %0d in range, %0d clamped low, %0d clamped high",
             n_in_range, n_clamp_low, n_clamp_high);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> gain_scheduled_pid_fuel_top.f
sv/gspf_pkg.sv
sv/gspf_sat_mul.sv
sv/gain_scheduled_pid_fuel_top.sv
sim/fuel_pid_checker.sv
sim/tb_top.sv
